// ===== design/wtd_pkg.sv =====
// Package for the waypoint turn-then-drive step: constants, types, tables.
// Used by the controller, datapath and top level.
`default_nettype none
package wtd_pkg;
    localparam int AngleFracBits = 13;
    localparam int CordicIters   = 16;
    localparam int IterW         = 5;
    localparam int DW            = 36;
    localparam int ZW            = 36;
    localparam logic [ZW-1:0] PiQ30     = 36'd3373259426;
    localparam logic [ZW-1:0] HalfPiQ30 = 36'd1686629713;
    localparam logic [DW-1:0] GainQ30   = 36'd652032874;
    localparam logic [12:0]   MarginReset = 13'd713;

    localparam logic [2:0] RegTargetX = 3'd0;
    localparam logic [2:0] RegTargetY = 3'd1;
    localparam logic [2:0] RegAdvance = 3'd2;
    localparam logic [2:0] RegTurn    = 3'd3;
    localparam logic [2:0] RegMargin  = 3'd4;

    localparam logic [1:0] ActHeld = 2'd0;
    localparam logic [1:0] ActAdv  = 2'd1;
    localparam logic [1:0] ActUp   = 2'd2;
    localparam logic [1:0] ActDown = 2'd3;

    typedef struct packed {
        logic load_vec;
        logic iterate;
        logic decide;
        logic load_rot;
        logic mul;
        logic commit_move;
        logic hold;
    } t_cmd;

    typedef struct packed {
        logic iter_done;
        logic aligned;
    } t_status;

    function automatic logic [ZW-1:0] atan_q30(input logic [IterW-1:0] i);
        logic [ZW-1:0] r;
        case (i)
            5'd0:  r = 36'h03243F6A8;
            5'd1:  r = 36'h01DAC6705;
            5'd2:  r = 36'h00FADBAFC;
            5'd3:  r = 36'h007F56EA6;
            5'd4:  r = 36'h003FEAB76;
            5'd5:  r = 36'h001FFD55B;
            5'd6:  r = 36'h000FFFAAA;
            5'd7:  r = 36'h0007FFF55;
            5'd8:  r = 36'h0003FFFEA;
            5'd9:  r = 36'h0001FFFFD;
            5'd10: r = 36'h0000FFFFF;
            5'd11: r = 36'h00007FFFF;
            5'd12: r = 36'h00003FFFF;
            5'd13: r = 36'h00001FFFF;
            5'd14: r = 36'h00000FFFF;
            5'd15: r = 36'h000007FFF;
            5'd16: r = 36'h000003FFF;
            5'd17: r = 36'h000001FFF;
            5'd18: r = 36'h000000FFF;
            5'd19: r = 36'h0000007FF;
            5'd20: r = 36'h0000003FF;
            5'd21: r = 36'h0000001FF;
            5'd22: r = 36'h0000000FF;
            5'd23: r = 36'h00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== design/wtd_ctrl.sv =====
// Controller FSM for the waypoint step: sequences both CORDIC passes and the move.
// Depends on wtd_pkg.
`default_nettype none
module wtd_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_enabled,
    input  wire              i_out_free,
    input  wtd_pkg::t_status i_status,
    output wtd_pkg::t_cmd    o_cmd,
    output logic             o_busy,
    output logic             o_done
);
    import wtd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_VEC  = 8'b00000010,
        S_DEC  = 8'b00000100,
        S_ROT  = 8'b00001000,
        S_MUL  = 8'b00010000,
        S_ADD  = 8'b00100000,
        S_OUT  = 8'b01000000,
        S_LOAD = 8'b10000000
    } t_state;

    t_state r_state, n_state;

    // Advance the sequence
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_done  = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                if (i_enabled) begin
                    o_cmd.load_vec = 1'b1;
                    n_state = S_VEC;
                end else begin
                    o_cmd.hold = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_VEC: begin
                o_cmd.iterate = 1'b1;
                if (i_status.iter_done) n_state = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state = i_status.aligned ? S_LOAD : S_OUT;
            end
            S_LOAD: begin
                o_cmd.load_rot = 1'b1;
                n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.iterate = 1'b1;
                if (i_status.iter_done) n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state = S_ADD;
            end
            S_ADD: begin
                o_cmd.commit_move = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: if (i_out_free) begin
                o_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end
endmodule
`default_nettype wire

// ===== design/wtd_dp.sv =====
// Datapath for the waypoint step: kept state, shared CORDIC stage, move arithmetic.
// Depends on wtd_pkg.
`default_nettype none
module wtd_dp (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wtd_pkg::t_cmd       i_cmd,
    input  wire                 i_cfg_we,
    input  wire          [2:0]  i_cfg_idx,
    input  wire          [31:0] i_cfg_data,
    output wtd_pkg::t_status    o_status,
    output logic signed  [31:0] o_pos_x,
    output logic signed  [31:0] o_pos_y,
    output logic signed  [15:0] o_heading,
    output logic         [1:0]  o_action
);
    import wtd_pkg::*;

    logic signed [31:0] r_tx, r_ty;
    logic        [19:0] r_adv;
    logic        [12:0] r_turn, r_margin;
    logic signed [31:0] r_px, r_py;
    logic signed [15:0] r_hd;
    logic        [1:0]  r_act;

    logic signed [DW-1:0] r_x, r_y;
    logic signed [ZW-1:0] r_z;
    logic                 r_mode_rot, r_neg;
    logic [IterW-1:0]     r_it;
    logic signed [53:0]   r_mx, r_my;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx <= '0; r_ty <= '0; r_adv <= '0; r_turn <= '0;
            r_margin <= MarginReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegTargetX: r_tx <= i_cfg_data;
                RegTargetY: r_ty <= i_cfg_data;
                RegAdvance: r_adv <= i_cfg_data[19:0];
                RegTurn:    r_turn <= i_cfg_data[12:0];
                RegMargin:  r_margin <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Vectoring set-up: fold left half plane
    logic signed [DW-1:0] dx, dy;
    assign dx = DW'(r_tx) - DW'(r_px);
    assign dy = DW'(r_ty) - DW'(r_py);

    // Rotation set-up: reduce heading (|h| <= 4 rad, so one fold of 2pi at most)
    logic signed [ZW-1:0] hz, hz1, hz2;
    logic                 hneg;
    always_comb begin
        hz = ZW'(r_hd) <<< (30 - AngleFracBits);
        hz1 = hz;
        if (hz > $signed(PiQ30)) hz1 = hz - $signed(PiQ30 << 1);
        else if (hz < -$signed(PiQ30)) hz1 = hz + $signed(PiQ30 << 1);
        hz2 = hz1; hneg = 1'b0;
        if (hz1 > $signed(HalfPiQ30)) begin
            hz2 = hz1 - $signed(PiQ30); hneg = 1'b1;
        end else if (hz1 < -$signed(HalfPiQ30)) begin
            hz2 = hz1 + $signed(PiQ30); hneg = 1'b1;
        end
    end

    // One shared CORDIC micro-rotation
    logic signed [DW-1:0] xs, ys;
    logic                 dir_pos;
    assign xs = r_x >>> r_it;
    assign ys = r_y >>> r_it;
    assign dir_pos = r_mode_rot ? (r_z >= 0) : (r_y < 0);
    assign o_status.iter_done = (r_it == IterW'(CordicIters - 1));

    // Bearing rounding and margin compare
    logic signed [ZW-1:0] zr;
    logic signed [18:0]   b, h, m;
    logic                 zero_vec;
    assign zr = (r_z + ZW'(1 << (29 - AngleFracBits))) >>> (30 - AngleFracBits);
    assign b  = zero_vec ? '0 : zr[18:0];
    assign h  = 19'(r_hd);
    assign m  = 19'({1'b0, r_margin});
    assign o_status.aligned = (h <= b + m) && (h >= b - m);
    logic r_zero;
    assign zero_vec = r_zero;

    logic signed [16:0] hup, hdn;
    assign hup = 17'(r_hd) + 17'({1'b0, r_turn});
    assign hdn = 17'(r_hd) - 17'({1'b0, r_turn});

    logic signed [DW-1:0] cx, sy;
    assign cx = r_neg ? -r_x : r_x;
    assign sy = r_neg ? -r_y : r_y;

    logic signed [53:0] mvx, mvy;
    logic signed [32:0] sx, syy;
    assign mvx = (r_mx + 54'sd536870912) >>> 30;
    assign mvy = (r_my + 54'sd536870912) >>> 30;
    assign sx  = 33'(r_px) + mvx[32:0];
    assign syy = 33'(r_py) + mvy[32:0];

    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        if (v > 33'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -33'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0; r_py <= '0; r_hd <= '0; r_act <= ActHeld;
        end else begin
            if (i_cmd.hold) r_act <= ActHeld;
            if (i_cmd.decide && !o_status.aligned) begin
                if (h < b) begin
                    r_hd  <= (hup > 17'sd32767) ? 16'sh7FFF : hup[15:0];
                    r_act <= ActUp;
                end else begin
                    r_hd  <= (hdn < -17'sd32768) ? 16'sh8000 : hdn[15:0];
                    r_act <= ActDown;
                end
            end
            if (i_cmd.commit_move) begin
                r_px  <= sat32(sx);
                r_py  <= sat32(syy);
                r_act <= ActAdv;
            end
        end
    end

    // CORDIC registers and products
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vec) begin
            r_mode_rot <= 1'b0;
            r_it <= '0;
            r_zero <= (dx == 0) && (dy == 0);
            if (dx < 0) begin
                r_x <= -dx; r_y <= -dy;
                r_z <= (dy >= 0) ? $signed(PiQ30) : -$signed(PiQ30);
            end else begin
                r_x <= dx; r_y <= dy; r_z <= '0;
            end
        end else if (i_cmd.load_rot) begin
            r_mode_rot <= 1'b1;
            r_it <= '0;
            r_x <= GainQ30; r_y <= '0; r_z <= hz2; r_neg <= hneg;
        end else if (i_cmd.iterate) begin
            r_it <= r_it + 1'b1;
            if (r_mode_rot ? dir_pos : !dir_pos) begin
                r_x <= r_mode_rot ? r_x - ys : r_x + ys;
                r_y <= r_mode_rot ? r_y + xs : r_y - xs;
                r_z <= r_mode_rot ? r_z - atan_q30(r_it) : r_z + atan_q30(r_it);
            end else begin
                r_x <= r_mode_rot ? r_x + ys : r_x - ys;
                r_y <= r_mode_rot ? r_y - xs : r_y + xs;
                r_z <= r_mode_rot ? r_z + atan_q30(r_it) : r_z - atan_q30(r_it);
            end
        end
        if (i_cmd.mul) begin
            r_mx <= $signed({1'b0, r_adv}) * $signed(cx[32:0]);
            r_my <= $signed({1'b0, r_adv}) * $signed(sy[32:0]);
        end
    end

    assign o_pos_x   = r_px;
    assign o_pos_y   = r_py;
    assign o_heading = r_hd;
    assign o_action  = r_act;
endmodule
`default_nettype wire

// ===== design/waypoint_turn_then_drive_step.sv =====
// Top level of the waypoint turn-then-drive step: stream ports around controller
// and datapath. Depends on wtd_pkg, wtd_ctrl and wtd_dp.
`default_nettype none
// One input transfer is one tick. A held tick (enabled low) gives its result
// without any CORDIC pass; a turning tick after 16 vectoring CORDIC iterations
// on one shared shift-add stage; a driving tick after a second 16-iteration
// rotation pass and a registered multiply as well. One tick is in work at a
// time; the next is taken once the result transfer has completed.
module waypoint_turn_then_drive_step (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [0] enabled
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [87:0] m_tdata,   // position_x, position_y, heading_now, action_taken
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_idx,
    input  wire  [31:0] i_cfg_data
);
    import wtd_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    busy, done;
    logic signed [31:0] px, py;
    logic signed [15:0] hd;
    logic [1:0] act;

    // Take a new tick only when idle and no result is waiting
    assign s_tready = !busy && !m_tvalid;

    wtd_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(s_tvalid && s_tready),
        .i_enabled(s_tdata[0]), .i_out_free(!m_tvalid || m_tready),
        .i_status(st), .o_cmd(cmd), .o_busy(busy), .o_done(done)
    );

    wtd_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .o_status(st),
        .o_pos_x(px), .o_pos_y(py), .o_heading(hd), .o_action(act)
    );

    // Output register: hold result until the transfer completes
    logic        r_mv;
    logic [87:0] r_md;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv <= 1'b0;
        else if (done) r_mv <= 1'b1;
        else if (m_tready) r_mv <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (done) r_md <= {6'd0, act, hd, py, px};
    end
    assign m_tvalid = r_mv;
    assign m_tdata  = r_md;
endmodule
`default_nettype wire

// ===== design/waypoint_turn_then_drive_step_chk.sv =====
// Port-level checker for the waypoint step, bound to the top level.
// Depends on nothing beyond the top-level ports.
`default_nettype none
module waypoint_turn_then_drive_step_chk (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire [7:0]  s_tdata,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [87:0] m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready) else $error("second tick taken");
    a_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready && !s_tdata[0] |=> ##1 m_tvalid && m_tdata[81:80] == 2'd0)
        else $error("held tick wrong");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !s_tready) else $error("accept during result");
endmodule

bind waypoint_turn_then_drive_step waypoint_turn_then_drive_step_chk u_chk (.*);
`default_nettype wire
